### hw/rtl/assoc_cache_fifo_lru_hit_counter_core_macros.svh
// Assertion macros shared by the cache hit counter RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSOC_CACHE_FIFO_LRU_HIT_COUNTER_CORE_MACROS_SVH
`define ASSOC_CACHE_FIFO_LRU_HIT_COUNTER_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ACHC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("achc: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ACHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("achc: implication violated");

`endif

### hw/rtl/achc_pkg.sv
// Shared types and constants for the cache hit counter.
// Used by every module of the block; depends on nothing.
package achc_pkg;

	// Configuration port geometry.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned ENTRIES_W  = 6;
	localparam int unsigned MEMSIZE_W  = 8;
	localparam int unsigned TOTAL_W    = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_BLOCKS = 2'd2;

	// Register reset values.
	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 6'd8;
	localparam logic [MEMSIZE_W-1:0] MEMSIZE_RESET = 8'd128;

	// Replacement policy codes.
	typedef enum logic {
		POL_FIFO = 1'b0,
		POL_LRU  = 1'b1
	} policy_t;

	// Control from the configuration registers to the back end.
	typedef struct packed {
		logic    flush;
		policy_t policy;
	} back_ctl_t;

endpackage

### hw/rtl/achc_queue.sv
// Small FIFO queue that decouples the front end from the back end.
// Uses achc_pkg for its depth.
module achc_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned DEPTH = achc_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage is written at the tail; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/achc_front.sv
// Front end: accepts block references, flags those beyond memory size.
// Uses achc_pkg; feeds achc_queue.
module achc_front #(
	parameter int unsigned BLOCK_BITS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [BLOCK_BITS-1:0]             block_number,
	input  logic [achc_pkg::MEMSIZE_W-1:0]    memory_blocks,
	input  logic                              queue_full,
	output logic                              push,
	output logic [BLOCK_BITS:0]               push_data
);

	localparam int unsigned CMP_W =
		(BLOCK_BITS > achc_pkg::MEMSIZE_W) ? BLOCK_BITS : achc_pkg::MEMSIZE_W;

	logic                  valid_s1;
	logic                  oor_s1;
	logic [BLOCK_BITS-1:0] blk_s1;
	logic                  in_fire;
	logic                  oor;

	// A reference at or above the memory size is flagged and later ignored.
	assign oor = (CMP_W'(block_number) >= CMP_W'(memory_blocks));

	assign push      = valid_s1 && !queue_full;
	assign in_ready  = !valid_s1 || !queue_full;
	assign in_fire   = in_valid && in_ready;
	assign push_data = {oor_s1, blk_s1};

	// Classified item register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_s1 <= block_number;
			oor_s1 <= oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

### hw/rtl/achc_back.sv
// Back end: parallel tag lookup, FIFO or LRU update, saturating counts.
// Uses achc_pkg; pops items from achc_queue.
module achc_back #(
	parameter int unsigned MAX_ENTRIES = 32,
	parameter int unsigned BLOCK_BITS  = 7,
	parameter int unsigned COUNT_BITS  = 16,
	parameter int unsigned EW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  achc_pkg::back_ctl_t              ctl,
	input  logic [EW-1:0]                    active_slots,
	input  logic                             queue_empty,
	input  logic [BLOCK_BITS:0]              pop_data,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic                             out_of_range,
	output logic [achc_pkg::TOTAL_W-1:0]     hit_total,
	output logic [achc_pkg::TOTAL_W-1:0]     reference_total
);

	localparam int unsigned PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [BLOCK_BITS-1:0] tag_q   [MAX_ENTRIES];
	logic [BLOCK_BITS-1:0] tag_d   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [MAX_ENTRIES-1:0] valid_d;
	logic [MAX_ENTRIES-1:0] act;
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] below;
	logic [EW-1:0]          fill_q;
	logic [EW-1:0]          fill_d;
	logic [PW-1:0]          oldest_q;
	logic [PW-1:0]          oldest_d;
	logic [PW-1:0]          oldest_use;
	logic [EW-1:0]          oldest_inc;
	logic [PW-1:0]          dst;
	logic [COUNT_BITS-1:0]  hit_cnt_q;
	logic [COUNT_BITS-1:0]  ref_cnt_q;
	logic                   out_valid_q;
	logic                   hit_q;
	logic                   oor_q;
	logic [BLOCK_BITS-1:0]  blk;
	logic                   oor;
	logic                   upd;
	logic                   found;
	logic                   fifo_full;

	assign blk = pop_data[BLOCK_BITS-1:0];
	assign oor = pop_data[BLOCK_BITS];
	assign pop = !queue_empty && (!out_valid_q || out_ready);
	assign upd = pop && !oor;

	// Compare every active slot against the reference at once.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			act[i]   = (EW'(i) < active_slots);
			match[i] = valid_q[i] && act[i] && (tag_q[i] == blk);
		end
		below[0] = 1'b0;
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			below[i] = below[i-1] || match[i-1];
		end
		found = |match;
	end

	// FIFO victim: the next free slot, otherwise the oldest one.
	always_comb begin
		fifo_full  = !(fill_q < active_slots);
		oldest_use = (EW'(oldest_q) >= active_slots) ? '0 : oldest_q;
		oldest_inc = EW'(oldest_use) + EW'(1);
		dst        = fifo_full ? oldest_use : fill_q[PW-1:0];
	end

	// Next slot contents for both policies.
	always_comb begin
		tag_d    = tag_q;
		valid_d  = valid_q;
		fill_d   = fill_q;
		oldest_d = oldest_q;
		if (upd) begin
			if (ctl.policy == achc_pkg::POL_FIFO) begin
				if (!found) begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (PW'(i) == dst) begin
							tag_d[i]   = blk;
							valid_d[i] = 1'b1;
						end
					end
					if (fifo_full) begin
						oldest_d = (oldest_inc >= active_slots) ? '0 : oldest_inc[PW-1:0];
					end else begin
						fill_d = fill_q + EW'(1);
					end
				end
			end else begin
				// Entries up to the hit slot, or all active ones on a miss, move down.
				for (int i = 1; i < MAX_ENTRIES; i++) begin
					if (act[i] && !below[i]) begin
						tag_d[i]   = tag_q[i-1];
						valid_d[i] = valid_q[i-1];
					end
				end
				tag_d[0]   = blk;
				valid_d[0] = 1'b1;
			end
		end
	end

	// Tag storage needs no reset; the valid bits guard it.
	always_ff @(posedge clk) begin
		tag_q <= tag_d;
		if (pop) begin
			hit_q <= found && !oor;
			oor_q <= oor;
		end
	end

	// Control state, flush on a policy or size write, saturating counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fill_q      <= '0;
			oldest_q    <= '0;
			hit_cnt_q   <= '0;
			ref_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.flush) begin
				valid_q  <= '0;
				fill_q   <= '0;
				oldest_q <= '0;
			end else begin
				valid_q  <= valid_d;
				fill_q   <= fill_d;
				oldest_q <= oldest_d;
			end
			if (upd && (ref_cnt_q != '1)) begin
				ref_cnt_q <= ref_cnt_q + COUNT_BITS'(1);
			end
			if (upd && found && (hit_cnt_q != '1)) begin
				hit_cnt_q <= hit_cnt_q + COUNT_BITS'(1);
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign out_of_range    = oor_q;
	assign hit_total       = achc_pkg::TOTAL_W'(hit_cnt_q);
	assign reference_total = achc_pkg::TOTAL_W'(ref_cnt_q);

endmodule

### hw/rtl/assoc_cache_fifo_lru_hit_counter_core.sv
// Top level of the fully associative cache hit counter (FIFO or LRU).
// Depends on achc_pkg, achc_front, achc_queue, achc_back and the macro header.
// Flow: out_valid rises once an accepted item has passed the front register, the queue and
// the back end's result register.
// Throughput: one item per cycle while out_ready holds; the parallel lookup and update set it.
// Reset (arst_n low, asynchronous): all slots invalid, counts zero, registers at
// 8 entries, FIFO policy, 128 memory blocks; no clearing pass is needed.
`include "assoc_cache_fifo_lru_hit_counter_core_macros.svh"

module assoc_cache_fifo_lru_hit_counter_core #(
	parameter int unsigned MAX_ENTRIES = 32,
	parameter int unsigned BLOCK_BITS  = 7,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [achc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [achc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [BLOCK_BITS-1:0]             block_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              out_of_range,
	output logic [achc_pkg::TOTAL_W-1:0]      hit_total,
	output logic [achc_pkg::TOTAL_W-1:0]      reference_total
);

	localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned NW = (EW > achc_pkg::ENTRIES_W) ? EW : achc_pkg::ENTRIES_W;

	logic [achc_pkg::ENTRIES_W-1:0] entries_q;
	logic [achc_pkg::MEMSIZE_W-1:0] mem_blocks_q;
	achc_pkg::policy_t              policy_q;
	achc_pkg::back_ctl_t            ctl;
	logic [NW-1:0]                  entries_ext;
	logic [EW-1:0]                  active_slots;
	logic                           q_push;
	logic                           q_pop;
	logic                           q_full;
	logic                           q_empty;
	logic [BLOCK_BITS:0]            q_push_data;
	logic [BLOCK_BITS:0]            q_pop_data;

	// Register write decode; a write to the size or policy register flushes the cache.
	always_comb begin
		ctl.policy = policy_q;
		ctl.flush  = 1'b0;
		if (cfg_wen) begin
			unique case (cfg_index) inside
				achc_pkg::REG_CACHE_ENTRIES, achc_pkg::REG_POLICY: ctl.flush = 1'b1;
				default: ctl.flush = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q    <= achc_pkg::ENTRIES_RESET;
			policy_q     <= achc_pkg::POL_FIFO;
			mem_blocks_q <= achc_pkg::MEMSIZE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				achc_pkg::REG_CACHE_ENTRIES:
					entries_q <= cfg_wdata[achc_pkg::ENTRIES_W-1:0];
				achc_pkg::REG_POLICY:
					policy_q <= achc_pkg::policy_t'(cfg_wdata[0]);
				achc_pkg::REG_MEMORY_BLOCKS:
					mem_blocks_q <= cfg_wdata[achc_pkg::MEMSIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Active slot count: zero acts as one, large values are capped.
	always_comb begin
		entries_ext = NW'(entries_q);
		if (entries_ext == '0) begin
			active_slots = EW'(1);
		end else if (entries_ext > NW'(MAX_ENTRIES)) begin
			active_slots = EW'(MAX_ENTRIES);
		end else begin
			active_slots = entries_ext[EW-1:0];
		end
	end

	achc_front #(
		.BLOCK_BITS (BLOCK_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.block_number  (block_number),
		.memory_blocks (mem_blocks_q),
		.queue_full    (q_full),
		.push          (q_push),
		.push_data     (q_push_data)
	);

	achc_queue #(
		.WIDTH (BLOCK_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	achc_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.BLOCK_BITS  (BLOCK_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.EW          (EW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.active_slots    (active_slots),
		.queue_empty     (q_empty),
		.pop_data        (q_pop_data),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.out_of_range    (out_of_range),
		.hit_total       (hit_total),
		.reference_total (reference_total)
	);

	// The queue is never written when full nor read when empty.
	`ACHC_ASSERT_IMPL(a_no_push_full, clk, arst_n, q_push, !q_full)
	`ACHC_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, q_pop, !q_empty)
	// An ignored reference never reports a hit.
	`ACHC_ASSERT_IMPL(a_oor_no_hit, clk, arst_n, out_valid && out_of_range, !hit)
	// The active slot count stays within the cache.
	`ACHC_ASSERT_ALWAYS(a_slots_range, clk, arst_n,
		(active_slots != '0) && (active_slots <= EW'(MAX_ENTRIES)))

endmodule

### tb/sv/tb_assoc_cache_fifo_lru_hit_counter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cache hit counter core: a directed table, random
// reference streams under several register settings, and a hot-block run at full rate.
// Depends on achc_pkg and assoc_cache_fifo_lru_hit_counter_core.
module tb_assoc_cache_fifo_lru_hit_counter_core;

	localparam int unsigned MAX_ENTRIES = 32;
	localparam int unsigned BLOCK_BITS  = 7;
	localparam int unsigned LATENCY     = 3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOT_ITEMS   = 20;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned MAX_REPORTS = 30;
	localparam logic [achc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [achc_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic                         hit;
		logic                         oor;
		logic [achc_pkg::TOTAL_W-1:0] hits;
		logic [achc_pkg::TOTAL_W-1:0] refs;
	} lookup_t;

	typedef enum logic [1:0] {
		ROW_REF,
		ROW_REF_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [BLOCK_BITS-1:0]           blk;
		logic [achc_pkg::CFG_IDX_W-1:0]  idx;
		logic [achc_pkg::CFG_DATA_W-1:0] data;
		lookup_t                         res;
	} row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wen;
	logic [achc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [achc_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            in_valid;
	logic                            in_ready;
	logic [BLOCK_BITS-1:0]           block_number;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            hit;
	logic                            out_of_range;
	logic [achc_pkg::TOTAL_W-1:0]    hit_total;
	logic [achc_pkg::TOTAL_W-1:0]    reference_total;

	// Predictor state: registers and cache contents as the block should hold them.
	logic [achc_pkg::ENTRIES_W-1:0]  model_entries;
	achc_pkg::policy_t               model_policy;
	logic [achc_pkg::MEMSIZE_W-1:0]  model_memsize;
	logic [BLOCK_BITS-1:0]           slot_tag [MAX_ENTRIES];
	bit                              slot_used [MAX_ENTRIES];
	int unsigned                     oldest;
	int unsigned                     fill;
	logic [achc_pkg::TOTAL_W-1:0]    hit_cnt;
	logic [achc_pkg::TOTAL_W-1:0]    ref_cnt;

	lookup_t                 expected_lookups [$];
	row_t                    directed [$];
	logic                    typed_pending;
	lookup_t                 typed_lookup;
	bit                      quiet;
	int unsigned             errors;
	int unsigned             cycles;
	int unsigned             refs_sent;
	int unsigned             hits_seen;
	int unsigned             oor_seen;
	int unsigned             cfg_writes;

	assoc_cache_fifo_lru_hit_counter_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.block_number    (block_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.out_of_range    (out_of_range),
		.hit_total       (hit_total),
		.reference_total (reference_total)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle guard: a hung handshake ends the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				expected_lookups.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Invalidate every slot; the counts survive.
	function automatic void model_flush();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slot_tag[i] = '0;
			slot_used[i] = 1'b0;
		end
		oldest = 0;
		fill = 0;
	endfunction

	function automatic void model_write(logic [achc_pkg::CFG_IDX_W-1:0] idx,
		logic [achc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
		achc_pkg::REG_CACHE_ENTRIES: begin
			model_entries = data[achc_pkg::ENTRIES_W-1:0];
			model_flush();
		end
		achc_pkg::REG_POLICY: begin
			model_policy = achc_pkg::policy_t'(data[0]);
			model_flush();
		end
		achc_pkg::REG_MEMORY_BLOCKS: begin
			model_memsize = data[achc_pkg::MEMSIZE_W-1:0];
		end
		default: begin
		end
		endcase
	endfunction

	// Look up one block, update the cache and counts, and return the expected result.
	function automatic lookup_t cache_lookup(logic [BLOCK_BITS-1:0] blk);
		lookup_t r;
		int n;
		int pos;
		int top;
		int dst;
		int i;
		bit found;
		n = model_entries;
		if (n < 1) n = 1;
		if (n > MAX_ENTRIES) n = MAX_ENTRIES;
		found = 1'b0;
		pos = 0;
		r.oor = int'(blk) >= int'(model_memsize);
		if (!r.oor) begin
			for (i = 0; i < n; i++) begin
				if (!found && slot_used[i] && slot_tag[i] == blk) begin
					found = 1'b1;
					pos = i;
				end
			end
			if (ref_cnt != TOTAL_MAX) ref_cnt++;
			if (found && hit_cnt != TOTAL_MAX) hit_cnt++;
			if (model_policy == achc_pkg::POL_FIFO) begin
				// A miss fills the next free slot, or overwrites the oldest one.
				if (!found) begin
					if (fill < n) begin
						dst = fill;
						fill++;
					end else begin
						if (oldest >= n) oldest = 0;
						dst = oldest;
						oldest = (oldest + 1 >= n) ? 0 : oldest + 1;
					end
					slot_tag[dst] = blk;
					slot_used[dst] = 1'b1;
				end
			end else begin
				// Recency order: shift down to the hit position, or drop the last slot.
				top = found ? pos : n - 1;
				for (i = top; i > 0; i--) begin
					slot_tag[i] = slot_tag[i-1];
					slot_used[i] = slot_used[i-1];
				end
				slot_tag[0] = blk;
				slot_used[0] = 1'b1;
			end
		end
		r.hit = found;
		r.hits = hit_cnt;
		r.refs = ref_cnt;
		return r;
	endfunction

	function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endfunction

	// Scoreboard: predict on each accepted item, compare on each accepted result.
	always @(posedge clk) begin
		lookup_t want;
		lookup_t seen;
		if (in_valid && in_ready) begin
			want = cache_lookup(block_number);
			if (typed_pending) want = typed_lookup;
			expected_lookups.push_back(want);
		end
		if (out_valid && out_ready) begin
			seen = '{hit, out_of_range, hit_total, reference_total};
			if (expected_lookups.size() == 0) begin
				flag_mismatch("unexpected result, hit_total", 0, seen.hits);
			end else begin
				want = expected_lookups.pop_front();
				if (want.hit) hits_seen++;
				if (want.oor) oor_seen++;
				if (seen.hit !== want.hit) flag_mismatch("hit", want.hit, seen.hit);
				if (seen.oor !== want.oor) flag_mismatch("out_of_range", want.oor, seen.oor);
				if (seen.hits !== want.hits) flag_mismatch("hit_total", want.hits, seen.hits);
				if (seen.refs !== want.refs)
					flag_mismatch("reference_total", want.refs, seen.refs);
			end
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(0, 99) >= 7);
	end

	// Offer one item and hold it until accepted; called and returns at a falling edge.
	task automatic send_block(logic [BLOCK_BITS-1:0] blk, logic typed, lookup_t res);
		bit done;
		if (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		block_number <= blk;
		typed_pending <= typed;
		typed_lookup <= res;
		refs_sent++;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			done = in_ready;
			@(negedge clk);
		end
	endtask

	// Stop offering items and wait until every expected result has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [achc_pkg::CFG_IDX_W-1:0] idx,
		logic [achc_pkg::CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		model_write(idx, data);
		cfg_writes++;
	endtask

	function automatic void add_ref(logic [BLOCK_BITS-1:0] blk);
		directed.push_back('{ROW_REF, blk, '0, '0, '0});
	endfunction

	function automatic void add_typed(logic [BLOCK_BITS-1:0] blk, logic h, logic o,
		int unsigned hits, int unsigned refs);
		lookup_t r;
		r = '{h, o, hits[achc_pkg::TOTAL_W-1:0], refs[achc_pkg::TOTAL_W-1:0]};
		directed.push_back('{ROW_REF_TYPED, blk, '0, '0, r});
	endfunction

	function automatic void add_cfg(logic [achc_pkg::CFG_IDX_W-1:0] idx,
		logic [achc_pkg::CFG_DATA_W-1:0] data);
		directed.push_back('{ROW_CFG, '0, idx, data, '0});
	endfunction

	// Pick a block: mostly from a working set, sometimes anywhere in the field.
	function automatic logic [BLOCK_BITS-1:0] pick_block(ref logic [BLOCK_BITS-1:0] pool [$]);
		if (pool.size() != 0 && $urandom_range(0, 99) < 80)
			return pool[$urandom_range(0, pool.size() - 1)];
		return BLOCK_BITS'($urandom_range(0, (1 << BLOCK_BITS) - 1));
	endfunction

	function automatic void fill_pool(ref logic [BLOCK_BITS-1:0] pool [$], input int size);
		int lim;
		lim = int'(model_memsize);
		if (lim == 0 || lim > (1 << BLOCK_BITS)) lim = 1 << BLOCK_BITS;
		pool.delete();
		for (int i = 0; i < size; i++)
			pool.push_back(BLOCK_BITS'($urandom_range(0, lim - 1)));
	endfunction

	// Stimulus sequence.
	initial begin
		logic [BLOCK_BITS-1:0] pool [$];
		logic [achc_pkg::CFG_DATA_W-1:0] entries_val;
		logic [achc_pkg::CFG_DATA_W-1:0] mem_val;
		logic [achc_pkg::CFG_DATA_W-1:0] pol_val;
		int active;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		block_number = '0;
		typed_pending = 1'b0;
		typed_lookup = '0;
		quiet = 1'b0;
		errors = 0;
		cycles = 0;
		refs_sent = 0;
		hits_seen = 0;
		oor_seen = 0;
		cfg_writes = 0;
		model_entries = achc_pkg::ENTRIES_RESET;
		model_policy = achc_pkg::POL_FIFO;
		model_memsize = achc_pkg::MEMSIZE_RESET;
		hit_cnt = '0;
		ref_cnt = '0;
		model_flush();

		// Directed table: reset state, range limits, spare index, slot count extremes.
		add_typed(7'd0, 1'b0, 1'b0, 0, 1);
		add_typed(7'd127, 1'b0, 1'b0, 0, 2);
		add_typed(7'd0, 1'b1, 1'b0, 1, 3);
		add_cfg(achc_pkg::REG_MEMORY_BLOCKS, 8'd32);
		add_typed(7'd32, 1'b0, 1'b1, 1, 3);
		add_typed(7'd31, 1'b0, 1'b0, 1, 4);
		add_cfg(achc_pkg::REG_MEMORY_BLOCKS, 8'd0);
		add_typed(7'd0, 1'b0, 1'b1, 1, 4);
		add_cfg(achc_pkg::REG_MEMORY_BLOCKS, 8'hFF);
		add_cfg(REG_SPARE, 8'hFF);
		add_typed(7'd127, 1'b1, 1'b0, 2, 5);
		// Zero entries behaves as a single slot.
		add_cfg(achc_pkg::REG_CACHE_ENTRIES, 8'd0);
		add_ref(7'd5);
		add_ref(7'd5);
		add_ref(7'd6);
		add_ref(7'd5);
		add_cfg(achc_pkg::REG_POLICY, 8'hFF);
		add_ref(7'd7);
		add_ref(7'd7);
		// Oversized entry count is limited to the slot array.
		add_cfg(achc_pkg::REG_CACHE_ENTRIES, 8'hFF);
		add_ref(7'd0);
		add_ref(7'd1);
		add_ref(7'd2);
		add_ref(7'd0);
		add_ref(7'd127);
		add_cfg(achc_pkg::REG_CACHE_ENTRIES, 8'd32);
		add_cfg(achc_pkg::REG_POLICY, 8'd0);
		add_ref(7'd3);
		add_ref(7'd3);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[k]) begin
			case (directed[k].kind)
			ROW_CFG: write_reg(directed[k].idx, directed[k].data);
			ROW_REF_TYPED: send_block(directed[k].blk, 1'b1, directed[k].res);
			default: send_block(directed[k].blk, 1'b0, '0);
			endcase
		end

		// Random phases, each under its own settings; the first four are the extremes.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: begin entries_val = 8'd1;  pol_val = 8'd0; mem_val = 8'd32;  end
			1: begin entries_val = 8'd32; pol_val = 8'd1; mem_val = 8'd128; end
			2: begin entries_val = 8'd32; pol_val = 8'd0; mem_val = 8'd64;  end
			3: begin entries_val = 8'd1;  pol_val = 8'd1; mem_val = 8'd255; end
			default: begin
				entries_val = 8'($urandom_range(0, 255));
				pol_val = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 3))
				0: mem_val = 8'd32;
				1: mem_val = 8'd64;
				2: mem_val = 8'd128;
				default: mem_val = 8'($urandom_range(0, 255));
				endcase
			end
			endcase
			write_reg(achc_pkg::REG_CACHE_ENTRIES, entries_val);
			write_reg(achc_pkg::REG_POLICY, pol_val);
			write_reg(achc_pkg::REG_MEMORY_BLOCKS, mem_val);
			if (p == 5) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
			active = int'(model_entries);
			if (active < 1) active = 1;
			if (active > MAX_ENTRIES) active = MAX_ENTRIES;
			fill_pool(pool, active + $urandom_range(1, 4));
			// One phase runs without any idling on either side.
			quiet = (p == 2);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if (j == PHASE_ITEMS / 2) wait_drained();
				send_block(pick_block(pool), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		// Hammer one hot block in a small LRU cache at full rate, then a mixed tail.
		write_reg(achc_pkg::REG_CACHE_ENTRIES, 8'd4);
		write_reg(achc_pkg::REG_POLICY, 8'd1);
		write_reg(achc_pkg::REG_MEMORY_BLOCKS, 8'd128);
		quiet = 1'b1;
		for (int j = 0; j < HOT_ITEMS; j++) send_block(7'd9, 1'b0, '0);
		quiet = 1'b0;
		fill_pool(pool, 6);
		for (int j = 0; j < 30; j++) send_block(pick_block(pool), 1'b0, '0);

		wait_drained();
		repeat (LATENCY + 5) @(negedge clk);
		$display("Ran %0d references (%0d hits, %0d out of range) over %0d register writes,",
			refs_sent, hits_seen, oor_seen, cfg_writes);
		$display("both policies, zero to oversized slot counts, stalls and full rate; %0d mismatches.",
			errors);
		if (errors == 0 && expected_lookups.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
